### hw/rtl/chained_display_command_parser_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chained display command parser
// Concurrent checks sampled on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef CHAINED_DISPLAY_COMMAND_PARSER_MACROS_SVH
`define CHAINED_DISPLAY_COMMAND_PARSER_MACROS_SVH

// same-cycle implication
`define CDCP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CDCP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cdcp_pkg.sv
// ----------------------------------------------------------------------------
// cdcp_pkg: shared types and constants
// Action codes, character and command codes, and the result item layout.
// ----------------------------------------------------------------------------
package cdcp_pkg;

    typedef enum logic [3:0] {
        ACT_CHAR    = 4'd0,
        ACT_DP      = 4'd1,
        ACT_RAW     = 4'd2,
        ACT_BRIGHT  = 4'd3,
        ACT_SHOW    = 4'd4,
        ACT_NUMBER  = 4'd5,
        ACT_MEASURE = 4'd6,
        ACT_RESET   = 4'd7,
        ACT_WRITEID = 4'd8
    } action_t;

    typedef struct packed {
        logic        last;
        logic [13:0] value;
        logic [2:0]  mask;
        action_t     action;
    } result_t;

    localparam logic [9:0]  ADDR_ALL     = 10'd999;
    localparam logic [9:0]  ADDR_LIMIT   = 10'd998;
    localparam logic [9:0]  ID_MAX       = 10'd507;
    localparam logic [6:0]  BRIGHT_MAX   = 7'd63;
    localparam logic [13:0] ID_ERASE     = 14'h3FFF;
    localparam logic [2:0]  MASK_ALL     = 3'b111;

    localparam logic [7:0]  CH_TAB   = 8'd9;
    localparam logic [7:0]  CH_LF    = 8'd10;
    localparam logic [7:0]  CH_CR    = 8'd13;
    localparam logic [7:0]  CH_SPACE = 8'd32;
    localparam logic [7:0]  CH_DEL   = 8'd127;
    localparam logic [7:0]  CH_DOT   = "." ;
    localparam logic [7:0]  CH_0     = "0";
    localparam logic [7:0]  CH_9     = "9";
    localparam logic [7:0]  CH_UA    = "A";
    localparam logic [7:0]  CH_UF    = "F";
    localparam logic [7:0]  CH_LA    = "a";
    localparam logic [7:0]  CH_LF_HEX = "f";
    localparam logic [7:0]  CH_B     = "B";

    localparam logic [23:0] CMD_TXT  = "TXT";
    localparam logic [23:0] CMD_RAW  = "RAW";
    localparam logic [23:0] CMD_RST  = "RST";
    localparam logic [23:0] CMD_IDQ  = "ID?";
    localparam logic [23:0] CMD_VDD  = "VDD";
    localparam logic [23:0] CMD_OER  = "OER";
    localparam logic [23:0] CMD_FER  = "FER";
    localparam logic [23:0] CMD_IDE  = "ID^";
    localparam logic [23:0] CMD_IDW  = "ID!";

endpackage

### hw/rtl/chained_display_command_parser.sv
// ----------------------------------------------------------------------------
// chained_display_command_parser: line parser for a chained 3-digit display
// Results: a byte passes the input register (in_*_reg), then its results are registered in out_data_reg.
// Throughput: one byte per cycle unless the output stalls; a byte with two results stalls input until both are taken.
// Reset: aresetn (sync, active low) clears parser state, counters, my_address.
// ----------------------------------------------------------------------------
`include "chained_display_command_parser_macros.svh"

module chained_display_command_parser
    import cdcp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [0] framing_error, [1] overrun_error
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] action, [6:4] digit_mask, [20:7] value
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data   // my_address
);

    typedef enum logic [2:0] {
        ST_CMD0, ST_CMD1, ST_CMD2, ST_CMD3, ST_TXT, ST_RAW1, ST_RAW2, ST_BAD
    } state_t;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic [3:0] dec_val(input logic [7:0] c);
        logic [7:0] d;
        d = c - CH_0;
        return d[3:0];
    endfunction

    function automatic logic mult3(input logic [4:0] s);
        logic r;
        case (s) inside
            5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd24, 5'd27: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic result_t mk(input action_t a, input logic [2:0] m,
                                   input logic [13:0] v);
        result_t r;
        r.last   = 1'b0;
        r.value  = v;
        r.mask   = m;
        r.action = a;
        return r;
    endfunction

    // parser state
    state_t      parse_state_reg, parse_state_next;
    logic        raw_mode_reg, raw_mode_next;
    logic [9:0]  origin_reg, origin_next;
    logic [9:0]  cur_addr_reg, cur_addr_next;
    logic [7:0]  cmd_reg [3];
    logic [7:0]  cmd_next [3];
    logic [7:0]  typed_reg [3];
    logic [7:0]  typed_next [3];
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic [7:0]  framing_count_reg, framing_count_next;
    logic [7:0]  overrun_count_reg, overrun_count_next;
    logic [9:0]  my_address_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_fe_reg;
    logic        in_oe_reg;

    // result slots: out is presented, out1 holds a second result
    logic        out_valid_reg;
    result_t     out_data_reg;
    logic        out1_valid_reg;
    result_t     out1_data_reg;

    logic        process;
    result_t     res0, res1;
    logic [1:0]  n_res;
    logic [2:0]  mask0, mask1;
    logic [23:0] cmd_word;
    logic [9:0]  cmd_num, typed_num;
    logic [6:0]  bright_num;
    logic [4:0]  typed_sum;
    logic        typed_ok;
    logic [3:0]  nib;
    logic        nib_ok;

    assign process   = in_valid_reg && !out1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || process;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_data_reg.value, out_data_reg.mask, out_data_reg.action};
    assign m_tlast  = out_data_reg.last;

    // digit masks for the current address (offset 0 and offset 1 for dp)
    always_comb begin
        logic [10:0] cur_ext;
        cur_ext = {1'b0, cur_addr_reg};
        for (int i = 0; i < 3; i++) begin
            mask0[i] = (cur_ext == ({1'b0, my_address_reg} + 11'(i)))
                       || (cur_addr_reg == ADDR_ALL);
            mask1[i] = (cur_ext == ({1'b0, my_address_reg} + 11'(i + 1)))
                       || (cur_addr_reg == ADDR_ALL);
        end
    end

    assign cmd_word   = {cmd_reg[0], cmd_reg[1], cmd_reg[2]};
    assign cmd_num    = 10'(dec_val(cmd_reg[0])) * 10'd100
                      + 10'(dec_val(cmd_reg[1])) * 10'd10 + 10'(dec_val(cmd_reg[2]));
    assign bright_num = 7'(dec_val(cmd_reg[1])) * 7'd10 + 7'(dec_val(cmd_reg[2]));
    assign typed_num  = 10'(dec_val(typed_reg[0])) * 10'd100
                      + 10'(dec_val(typed_reg[1])) * 10'd10 + 10'(dec_val(typed_reg[2]));
    assign typed_sum  = 5'(dec_val(typed_reg[0])) + 5'(dec_val(typed_reg[1]))
                      + 5'(dec_val(typed_reg[2]));
    assign typed_ok   = is_dec(typed_reg[0]) && is_dec(typed_reg[1]) && is_dec(typed_reg[2]);

    always_comb begin
        nib    = 4'd0;
        nib_ok = 1'b1;
        if (is_dec(in_byte_reg)) begin
            nib = dec_val(in_byte_reg);
        end else if (in_byte_reg >= CH_UA && in_byte_reg <= CH_UF) begin
            nib = 4'(in_byte_reg - CH_UA) + 4'd10;
        end else if (in_byte_reg >= CH_LA && in_byte_reg <= CH_LF_HEX) begin
            nib = 4'(in_byte_reg - CH_LA) + 4'd10;
        end else begin
            nib_ok = 1'b0;
        end
    end

    always_comb begin
        parse_state_next   = parse_state_reg;
        raw_mode_next      = raw_mode_reg;
        origin_next        = origin_reg;
        cur_addr_next      = cur_addr_reg;
        high_nibble_next   = high_nibble_reg;
        framing_count_next = framing_count_reg;
        overrun_count_next = overrun_count_reg;
        for (int i = 0; i < 3; i++) begin
            cmd_next[i]   = cmd_reg[i];
            typed_next[i] = typed_reg[i];
        end
        n_res = 2'd0;
        res0  = mk(ACT_SHOW, MASK_ALL, 14'd0);
        res1  = mk(ACT_SHOW, MASK_ALL, 14'd0);

        if (process) begin
            if (in_fe_reg) begin
                framing_count_next = framing_count_reg + 8'd1;
            end else if (in_oe_reg) begin
                overrun_count_next = overrun_count_reg + 8'd1;
            end else if (in_byte_reg == CH_CR || in_byte_reg == CH_LF) begin
                if (parse_state_reg == ST_CMD3) begin
                    if (is_dec(cmd_reg[0])) begin
                        if (is_dec(cmd_reg[1]) && is_dec(cmd_reg[2])) begin
                            origin_next = cmd_num;
                        end
                    end else if (cmd_word == CMD_TXT) begin
                        raw_mode_next = 1'b0;
                    end else if (cmd_word == CMD_RAW) begin
                        raw_mode_next = 1'b1;
                    end else if (cmd_word == CMD_RST) begin
                        res0  = mk(ACT_RESET, MASK_ALL, 14'd0);
                        n_res = 2'd1;
                    end else if (cmd_word == CMD_IDQ) begin
                        res0  = mk(ACT_NUMBER, MASK_ALL, 14'(my_address_reg));
                        n_res = 2'd2;
                    end else if (cmd_word == CMD_VDD) begin
                        res0  = mk(ACT_MEASURE, MASK_ALL, 14'd0);
                        n_res = 2'd1;
                    end else if (cmd_word == CMD_OER) begin
                        res0  = mk(ACT_NUMBER, MASK_ALL, 14'(overrun_count_reg));
                        n_res = 2'd2;
                    end else if (cmd_word == CMD_FER) begin
                        res0  = mk(ACT_NUMBER, MASK_ALL, 14'(framing_count_reg));
                        n_res = 2'd2;
                    end else if (cmd_reg[0] == CH_B) begin
                        if (is_dec(cmd_reg[1]) && is_dec(cmd_reg[2])) begin
                            if (mask0 != 3'b000) begin
                                res0 = mk(ACT_BRIGHT, mask0, (bright_num > BRIGHT_MAX)
                                          ? 14'(BRIGHT_MAX) : 14'(bright_num));
                                n_res = 2'd2;
                            end else begin
                                n_res = 2'd1;
                            end
                        end
                    end else if (cmd_word == CMD_IDE) begin
                        if (mask0[0]) begin
                            res0  = mk(ACT_WRITEID, MASK_ALL, ID_ERASE);
                            res1  = mk(ACT_RESET, MASK_ALL, 14'd0);
                            n_res = 2'd2;
                        end
                    end else if (cmd_word == CMD_IDW) begin
                        if (mask0[0]) begin
                            if (typed_ok && typed_num <= ID_MAX && mult3(typed_sum)
                                && cur_addr_reg != ADDR_ALL) begin
                                res0  = mk(ACT_WRITEID, MASK_ALL, 14'(typed_num));
                                res1  = mk(ACT_RESET, MASK_ALL, 14'd0);
                                n_res = 2'd2;
                            end else begin
                                res0  = mk(ACT_RESET, MASK_ALL, 14'd0);
                                n_res = 2'd1;
                            end
                        end
                    end
                end else if (parse_state_reg == ST_TXT || parse_state_reg == ST_RAW1) begin
                    n_res = 2'd1;
                end
                parse_state_next = raw_mode_next ? ST_RAW1 : ST_TXT;
                cur_addr_next    = origin_next;
            end else if (in_byte_reg == CH_TAB && parse_state_reg != ST_BAD) begin
                parse_state_next = ST_CMD0;
            end else if (in_byte_reg >= CH_SPACE && in_byte_reg <= CH_DEL) begin
                unique case (parse_state_reg)
                    ST_CMD0: begin
                        cmd_next[0]      = in_byte_reg;
                        parse_state_next = ST_CMD1;
                    end
                    ST_CMD1: begin
                        cmd_next[1]      = in_byte_reg;
                        parse_state_next = ST_CMD2;
                    end
                    ST_CMD2: begin
                        cmd_next[2]      = in_byte_reg;
                        parse_state_next = ST_CMD3;
                    end
                    ST_CMD3: parse_state_next = ST_BAD;
                    ST_TXT: begin
                        if (in_byte_reg == CH_DOT) begin
                            if (mask1 != 3'b000) begin
                                res0  = mk(ACT_DP, mask1, 14'd0);
                                n_res = 2'd1;
                            end
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                if (mask0[i]) typed_next[i] = in_byte_reg;
                            end
                            if (mask0 != 3'b000) begin
                                res0  = mk(ACT_CHAR, mask0, 14'(in_byte_reg));
                                n_res = 2'd1;
                            end
                            if (cur_addr_reg < ADDR_LIMIT) cur_addr_next = cur_addr_reg + 10'd1;
                        end
                    end
                    ST_RAW1: begin
                        if (!nib_ok) begin
                            parse_state_next = ST_BAD;
                        end else begin
                            high_nibble_next = nib;
                            parse_state_next = ST_RAW2;
                        end
                    end
                    ST_RAW2: begin
                        if (!nib_ok) begin
                            parse_state_next = ST_BAD;
                        end else begin
                            if (mask0 != 3'b000) begin
                                res0  = mk(ACT_RAW, mask0, 14'({high_nibble_reg, nib}));
                                n_res = 2'd1;
                            end
                            parse_state_next = ST_RAW1;
                            if (cur_addr_reg < ADDR_LIMIT) cur_addr_next = cur_addr_reg + 10'd1;
                        end
                    end
                    ST_BAD: ;
                endcase
            end
        end

        // final result of the byte carries last
        if (n_res == 2'd1) res0.last = 1'b1;
        if (n_res == 2'd2) res1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parse_state_reg   <= ST_TXT;
            raw_mode_reg      <= 1'b0;
            origin_reg        <= '0;
            cur_addr_reg      <= '0;
            high_nibble_reg   <= '0;
            framing_count_reg <= '0;
            overrun_count_reg <= '0;
            my_address_reg    <= '0;
            for (int i = 0; i < 3; i++) begin
                cmd_reg[i]   <= '0;
                typed_reg[i] <= '0;
            end
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out1_valid_reg <= 1'b0;
        end else begin
            parse_state_reg   <= parse_state_next;
            raw_mode_reg      <= raw_mode_next;
            origin_reg        <= origin_next;
            cur_addr_reg      <= cur_addr_next;
            high_nibble_reg   <= high_nibble_next;
            framing_count_reg <= framing_count_next;
            overrun_count_reg <= overrun_count_next;
            for (int i = 0; i < 3; i++) begin
                cmd_reg[i]   <= cmd_next[i];
                typed_reg[i] <= typed_next[i];
            end
            if (cfg_valid && cfg_ready) my_address_reg <= cfg_data;
            if (s_tready) in_valid_reg <= s_tvalid;
            if (process) begin
                out_valid_reg  <= (n_res != 2'd0);
                out1_valid_reg <= (n_res == 2'd2);
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg  <= out1_valid_reg;
                out1_valid_reg <= 1'b0;
            end
        end
        // payload registers
        if (s_tready) begin
            in_byte_reg <= s_tdata;
            in_fe_reg   <= s_tuser[0];
            in_oe_reg   <= s_tuser[1];
        end
        if (process) begin
            out_data_reg  <= res0;
            out1_data_reg <= res1;
        end else if (out_valid_reg && m_tready) begin
            out_data_reg <= out1_data_reg;
        end
    end

    `CDCP_ASSERT_IMP(a_pending_behind_out, out1_valid_reg, out_valid_reg, "second result without first")
    `CDCP_ASSERT_IMP(a_notlast_has_next, m_tvalid && !m_tlast, out1_valid_reg, "non-final result without follower")
    `CDCP_ASSERT_NXT(a_framing_count, process && in_fe_reg, framing_count_reg == $past(framing_count_reg) + 8'd1, "framing count not incremented")
    `CDCP_ASSERT_IMP(a_ready_when_empty, !in_valid_reg, s_tready, "input stalled while empty")

endmodule
